FILE: hdl/gaps_pkg.sv
// ----------------------------------------------------------------------------
// Grid A* path search package
// Shared types, request and response structs, and controller/datapath codes.
// ----------------------------------------------------------------------------
package gaps_pkg;

  localparam int unsigned CoordW = 6;
  localparam int unsigned IndexW = 12;
  localparam int unsigned DistW  = 12;
  localparam int unsigned LenW   = 13;
  localparam int unsigned CfgW   = 7;
  // Wide enough for any grid dimension up to 256 and for the 7-bit registers.
  localparam int unsigned DimW   = 9;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_RUN  = 2'd1,
    CMD_READ = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  typedef enum logic {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } cfg_idx_e;

  // Neighbour order of the search: +x, -x, +y, -y.
  typedef enum logic [1:0] {
    DIR_XP = 2'd0,
    DIR_XN = 2'd1,
    DIR_YP = 2'd2,
    DIR_YN = 2'd3
  } dir_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [CoordW-1:0] cell_x;
    logic [CoordW-1:0] cell_y;
    logic              wall_bit;
    logic [CoordW-1:0] goal_col;
    logic [CoordW-1:0] goal_row;
    logic [IndexW-1:0] path_index;
  } in_req_t;

  typedef struct packed {
    logic              found;
    logic [DistW-1:0]  distance;
    logic [LenW-1:0]   path_length;
    logic [CoordW-1:0] path_col;
    logic [CoordW-1:0] path_row;
    logic              overflow;
  } out_rsp_t;

  typedef enum logic [4:0] {
    DP_NONE,
    DP_SWEEP_WALL,
    DP_LATCH,
    DP_WALL,
    DP_READ,
    DP_MISC,
    DP_FAIL,
    DP_RUN_INIT,
    DP_SWEEP_COST,
    DP_START,
    DP_SWAP,
    DP_POP,
    DP_CUR,
    DP_CHK,
    DP_GOAL0,
    DP_PATH_INIT,
    DP_NEXT,
    DP_PROBE,
    DP_RELAX,
    DP_OVF,
    DP_PW,
    DP_PD,
    DP_RESULT
  } dp_op_e;

  typedef struct packed {
    cmd_e cmd;
    logic run_ok;
    logic sweep_last;
    logic open_empty;
    logic low_empty;
    logic stale;
    logic at_goal;
    logic g_zero;
    logic nb_ok;
    logic last_dir;
    logic improve;
    logic full;
    logic k_one;
  } dp_status_t;

endpackage

FILE: hdl/gaps_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gaps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/gaps_ctrl.sv
// ----------------------------------------------------------------------------
// Grid A* path search controller
// Sequences requests and the search steps; drives one datapath op per cycle.
// ----------------------------------------------------------------------------
module gaps_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  gaps_pkg::dp_status_t status_i,
  output gaps_pkg::dp_op_e     op_o
);
  import gaps_pkg::*;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_RESP,
    ST_CLEAR,
    ST_START,
    ST_POP,
    ST_POPW,
    ST_CHK,
    ST_NB,
    ST_NBW,
    ST_PW,
    ST_PD
  } state_e;

  state_e state_q, state_d;
  dp_op_e op;
  logic   out_valid_q;

  always_comb begin
    op      = DP_NONE;
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        op = DP_SWEEP_WALL;
        if (status_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          op      = DP_LATCH;
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (status_i.cmd)
          CMD_LOAD: begin
            op      = DP_WALL;
            state_d = ST_RESP;
          end
          CMD_READ: begin
            op      = DP_READ;
            state_d = ST_RESP;
          end
          CMD_RUN: begin
            if (status_i.run_ok) begin
              op      = DP_RUN_INIT;
              state_d = ST_CLEAR;
            end else begin
              op      = DP_FAIL;
              state_d = ST_RESP;
            end
          end
          default: begin
            op      = DP_MISC;
            state_d = ST_RESP;
          end
        endcase
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          op      = DP_RESULT;
          state_d = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        op = DP_SWEEP_COST;
        if (status_i.sweep_last) state_d = ST_START;
      end
      ST_START: begin
        op      = DP_START;
        state_d = ST_POP;
      end
      ST_POP: begin
        if (status_i.open_empty) begin
          state_d = ST_RESP;
        end else if (status_i.low_empty) begin
          op = DP_SWAP;
        end else begin
          op      = DP_POP;
          state_d = ST_POPW;
        end
      end
      ST_POPW: begin
        op      = DP_CUR;
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (status_i.stale) begin
          state_d = ST_POP;
        end else if (status_i.at_goal) begin
          if (status_i.g_zero) begin
            op      = DP_GOAL0;
            state_d = ST_RESP;
          end else begin
            op      = DP_PATH_INIT;
            state_d = ST_PW;
          end
        end else begin
          op      = DP_CHK;
          state_d = ST_NB;
        end
      end
      ST_NB: begin
        if (status_i.nb_ok) begin
          op      = DP_PROBE;
          state_d = ST_NBW;
        end else begin
          op      = DP_NEXT;
          state_d = status_i.last_dir ? ST_POP : ST_NB;
        end
      end
      ST_NBW: begin
        if (status_i.improve && status_i.full) begin
          op      = DP_OVF;
          state_d = ST_RESP;
        end else begin
          op      = status_i.improve ? DP_RELAX : DP_NEXT;
          state_d = status_i.last_dir ? ST_POP : ST_NB;
        end
      end
      ST_PW: begin
        op      = DP_PW;
        state_d = ST_PD;
      end
      ST_PD: begin
        op      = DP_PD;
        state_d = status_i.k_one ? ST_RESP : ST_PW;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (op == DP_RESULT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign op_o        = op;

endmodule

FILE: hdl/gaps_dp.sv
// ----------------------------------------------------------------------------
// Grid A* path search datapath
// Grid stores, two-level open list, search registers and the response register.
// ----------------------------------------------------------------------------
module gaps_dp #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64,
  parameter int unsigned OPEN_DEPTH = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  gaps_pkg::in_req_t         in_req_i,
  input  logic                      cfg_valid_i,
  input  gaps_pkg::cfg_idx_e        cfg_index_i,
  input  logic [gaps_pkg::CfgW-1:0] cfg_data_i,
  input  gaps_pkg::dp_op_e          op_i,
  output gaps_pkg::dp_status_t      status_o,
  output gaps_pkg::out_rsp_t        out_rsp_o
);
  import gaps_pkg::*;

  localparam int unsigned XW    = $clog2(MAX_WIDTH);
  localparam int unsigned YW    = $clog2(MAX_HEIGHT);
  localparam int unsigned CW    = XW + YW;
  localparam int unsigned Slots = 1 << CW;
  localparam int unsigned Cells = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned KW    = $clog2(Cells);
  localparam int unsigned GW    = $clog2(Cells) + 1;
  localparam int unsigned FW    = GW + 1;
  localparam int unsigned QW    = $clog2(OPEN_DEPTH);
  localparam int unsigned TW    = $clog2(OPEN_DEPTH + 1);
  localparam logic [GW-1:0] CostInf = '1;

  // Cells are addressed as {row, column}.
  logic [CfgW-1:0] grid_w_q, grid_h_q;
  in_req_t         req_q;
  logic [CW-1:0]   sweep_q;
  logic            found_q, ovf_q, rd_hit_q;
  logic [DistW-1:0] dist_q;
  logic [LenW-1:0]  len_q;
  logic            sel_q;
  logic [QW-1:0]   head_q [2];
  logic [QW-1:0]   tail_q [2];
  logic [TW-1:0]   cnt_q  [2];
  logic [TW-1:0]   total_q;
  logic [FW-1:0]   f_q;
  logic [CW-1:0]   cur_q, n_q, idx_q;
  logic [GW-1:0]   g_q;
  dir_e            dir_q;
  logic [KW-1:0]   k_q;
  out_rsp_t        out_q;

  logic [DimW-1:0] dim_w, dim_h;
  logic [CW-1:0]   start_c, goal_c, nb_c, pred_c, wall_c;
  logic            run_ok, wall_in, rd_hit;
  logic            wall_rd;
  logic [GW-1:0]   cost_rd;
  logic [1:0]      dir_rd;
  logic [CW-1:0]   path_rd;
  logic [CW-1:0]   q_rd [2];
  logic [FW-1:0]   f_new;
  logic            push_sel, nb_ok, stale, improve;

  function automatic logic [FW-1:0] dist_to(logic [CW-1:0] a, logic [CW-1:0] b);
    logic [DimW-1:0] ax, ay, bx, by, dx, dy;
    ax = DimW'(a[XW-1:0]);
    ay = DimW'(a[CW-1:XW]);
    bx = DimW'(b[XW-1:0]);
    by = DimW'(b[CW-1:XW]);
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    return FW'(dx) + FW'(dy);
  endfunction

  function automatic logic [QW-1:0] ptr_inc(logic [QW-1:0] p);
    return (p == QW'(OPEN_DEPTH - 1)) ? '0 : p + QW'(1);
  endfunction

  // A register of zero means one; larger than the maximum saturates.
  always_comb begin
    if (grid_w_q == '0) dim_w = DimW'(1);
    else if (DimW'(grid_w_q) > DimW'(MAX_WIDTH)) dim_w = DimW'(MAX_WIDTH);
    else dim_w = DimW'(grid_w_q);
    if (grid_h_q == '0) dim_h = DimW'(1);
    else if (DimW'(grid_h_q) > DimW'(MAX_HEIGHT)) dim_h = DimW'(MAX_HEIGHT);
    else dim_h = DimW'(grid_h_q);
  end

  assign start_c = {YW'(req_q.cell_y), XW'(req_q.cell_x)};
  assign wall_c  = start_c;
  assign goal_c  = {YW'(req_q.goal_row), XW'(req_q.goal_col)};
  assign run_ok  = (DimW'(req_q.cell_x) < dim_w) && (DimW'(req_q.cell_y) < dim_h) &&
                   (DimW'(req_q.goal_col) < dim_w) && (DimW'(req_q.goal_row) < dim_h);
  assign wall_in = (DimW'(req_q.cell_x) < DimW'(MAX_WIDTH)) &&
                   (DimW'(req_q.cell_y) < DimW'(MAX_HEIGHT));
  assign rd_hit  = (LenW'(req_q.path_index) < len_q) && (32'(req_q.path_index) < Cells);

  always_comb begin
    logic [XW-1:0] cx, px;
    logic [YW-1:0] cy, py;
    cx = cur_q[XW-1:0];
    cy = cur_q[CW-1:XW];
    nb_ok = 1'b0;
    nb_c  = cur_q;
    case (dir_q)
      DIR_XP: begin
        nb_ok = (DimW'(cx) + DimW'(1)) < dim_w;
        nb_c  = {cy, cx + XW'(1)};
      end
      DIR_XN: begin
        nb_ok = (cx != '0);
        nb_c  = {cy, cx - XW'(1)};
      end
      DIR_YP: begin
        nb_ok = (DimW'(cy) + DimW'(1)) < dim_h;
        nb_c  = {cy + YW'(1), cx};
      end
      DIR_YN: begin
        nb_ok = (cy != '0);
        nb_c  = {cy - YW'(1), cx};
      end
      default: ;
    endcase
    // Step back against the stored arrival direction.
    px = idx_q[XW-1:0];
    py = idx_q[CW-1:XW];
    case (dir_e'(dir_rd))
      DIR_XP:  px = px - XW'(1);
      DIR_XN:  px = px + XW'(1);
      DIR_YP:  py = py - YW'(1);
      DIR_YN:  py = py + YW'(1);
      default: ;
    endcase
    pred_c = {py, px};
  end

  assign stale   = (cost_rd == CostInf) || (f_q != FW'(cost_rd) + dist_to(cur_q, goal_c));
  assign improve = !wall_rd && ((GW+1)'(g_q) + (GW+1)'(1) < (GW+1)'(cost_rd));
  assign f_new   = FW'(g_q) + FW'(1) + dist_to(n_q, goal_c);
  // Equal f joins the current level; otherwise it is two higher.
  assign push_sel = (f_new == f_q) ? sel_q : ~sel_q;

  // Memory port steering.
  logic            wall_we, wall_wd, wall_re;
  logic [CW-1:0]   wall_wa;
  logic            cost_we, cost_re;
  logic [CW-1:0]   cost_wa, cost_ra;
  logic [GW-1:0]   cost_wd;
  logic            dir_we, dir_re;
  logic            path_we, path_re;
  logic [KW-1:0]   path_wa, path_ra;
  logic [CW-1:0]   path_wd;
  logic            q_we [2];
  logic            q_re [2];
  logic [QW-1:0]   q_wa [2];
  logic [CW-1:0]   q_wd;

  always_comb begin
    wall_we = 1'b0;  wall_wa = sweep_q;  wall_wd = 1'b0;  wall_re = 1'b0;
    cost_we = 1'b0;  cost_wa = n_q;      cost_wd = g_q + GW'(1);
    cost_re = 1'b0;  cost_ra = nb_c;
    dir_we  = 1'b0;  dir_re  = 1'b0;
    path_we = 1'b0;  path_wa = k_q;      path_wd = idx_q;
    path_re = 1'b0;  path_ra = KW'(req_q.path_index);
    q_wd    = n_q;
    for (int i = 0; i < 2; i++) begin
      q_we[i] = 1'b0;
      q_re[i] = (op_i == DP_POP) && (sel_q == 1'(i));
      q_wa[i] = tail_q[i];
    end
    unique case (op_i)
      DP_SWEEP_WALL: wall_we = 1'b1;
      DP_WALL: begin
        wall_we = wall_in;
        wall_wa = wall_c;
        wall_wd = req_q.wall_bit;
      end
      DP_READ: path_re = rd_hit;
      DP_SWEEP_COST: begin
        cost_we = 1'b1;
        cost_wa = sweep_q;
        cost_wd = CostInf;
      end
      DP_START: begin
        cost_we = 1'b1;
        cost_wa = start_c;
        cost_wd = '0;
        q_we[0] = 1'b1;
        q_wa[0] = '0;
        q_wd    = start_c;
      end
      DP_CUR: begin
        cost_re = 1'b1;
        cost_ra = q_rd[sel_q];
      end
      DP_GOAL0: begin
        path_we = 1'b1;
        path_wa = '0;
        path_wd = start_c;
      end
      DP_PROBE: begin
        wall_re = 1'b1;
        wall_wa = sweep_q;
        cost_re = 1'b1;
      end
      DP_RELAX: begin
        cost_we        = 1'b1;
        dir_we         = 1'b1;
        q_we[push_sel] = 1'b1;
      end
      DP_PW: begin
        path_we = 1'b1;
        dir_re  = 1'b1;
      end
      DP_PD: begin
        path_we = (k_q == KW'(1));
        path_wa = '0;
        path_wd = start_c;
      end
      default: ;
    endcase
  end

  gaps_ram #(.WIDTH(1), .DEPTH(Slots)) u_wall_ram (
    .clk_i, .we_i(wall_we), .waddr_i(wall_wa), .wdata_i(wall_wd),
    .re_i(wall_re), .raddr_i(nb_c), .rdata_o(wall_rd)
  );

  gaps_ram #(.WIDTH(GW), .DEPTH(Slots)) u_cost_ram (
    .clk_i, .we_i(cost_we), .waddr_i(cost_wa), .wdata_i(cost_wd),
    .re_i(cost_re), .raddr_i(cost_ra), .rdata_o(cost_rd)
  );

  gaps_ram #(.WIDTH(2), .DEPTH(Slots)) u_dir_ram (
    .clk_i, .we_i(dir_we), .waddr_i(n_q), .wdata_i(dir_q),
    .re_i(dir_re), .raddr_i(idx_q), .rdata_o(dir_rd)
  );

  gaps_ram #(.WIDTH(CW), .DEPTH(Cells)) u_path_ram (
    .clk_i, .we_i(path_we), .waddr_i(path_wa), .wdata_i(path_wd),
    .re_i(path_re), .raddr_i(path_ra), .rdata_o(path_rd)
  );

  for (genvar i = 0; i < 2; i++) begin : g_open
    gaps_ram #(.WIDTH(CW), .DEPTH(OPEN_DEPTH)) u_open_ram (
      .clk_i, .we_i(q_we[i]), .waddr_i(q_wa[i]), .wdata_i(q_wd),
      .re_i(q_re[i]), .raddr_i(head_q[i]), .rdata_o(q_rd[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_w_q <= CfgW'(64);
      grid_h_q <= CfgW'(64);
      sweep_q  <= '0;
      found_q  <= 1'b0;
      ovf_q    <= 1'b0;
      dist_q   <= '0;
      len_q    <= '0;
      rd_hit_q <= 1'b0;
      sel_q    <= 1'b0;
      total_q  <= '0;
      for (int i = 0; i < 2; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_GRID_WIDTH:  grid_w_q <= cfg_data_i;
          CFG_GRID_HEIGHT: grid_h_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (op_i)
        DP_SWEEP_WALL, DP_SWEEP_COST: sweep_q <= sweep_q + CW'(1);
        DP_WALL, DP_MISC: rd_hit_q <= 1'b0;
        DP_READ: rd_hit_q <= rd_hit;
        DP_FAIL, DP_RUN_INIT: begin
          found_q  <= 1'b0;
          ovf_q    <= 1'b0;
          dist_q   <= '0;
          len_q    <= '0;
          rd_hit_q <= 1'b0;
          sweep_q  <= '0;
        end
        DP_START: begin
          sel_q     <= 1'b0;
          head_q[0] <= '0;
          head_q[1] <= '0;
          tail_q[0] <= ptr_inc('0);
          tail_q[1] <= '0;
          cnt_q[0]  <= TW'(1);
          cnt_q[1]  <= '0;
          total_q   <= TW'(1);
        end
        DP_SWAP: sel_q <= ~sel_q;
        DP_POP: begin
          head_q[sel_q] <= ptr_inc(head_q[sel_q]);
          cnt_q[sel_q]  <= cnt_q[sel_q] - TW'(1);
          total_q       <= total_q - TW'(1);
        end
        DP_GOAL0, DP_PATH_INIT: begin
          found_q <= 1'b1;
          dist_q  <= DistW'(cost_rd);
          len_q   <= LenW'((GW+1)'(cost_rd) + (GW+1)'(1));
        end
        DP_OVF: ovf_q <= 1'b1;
        DP_RELAX: begin
          tail_q[push_sel] <= ptr_inc(tail_q[push_sel]);
          cnt_q[push_sel]  <= cnt_q[push_sel] + TW'(1);
          total_q          <= total_q + TW'(1);
        end
        default: ;
      endcase
    end
  end

  // Search payload registers.
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      DP_LATCH: req_q <= in_req_i;
      DP_START: f_q <= dist_to(start_c, goal_c);
      DP_SWAP: f_q <= f_q + FW'(2);
      DP_CUR: cur_q <= q_rd[sel_q];
      DP_CHK: begin
        g_q   <= cost_rd;
        dir_q <= DIR_XP;
      end
      DP_PATH_INIT: begin
        k_q   <= KW'(cost_rd);
        idx_q <= cur_q;
      end
      DP_PROBE: n_q <= nb_c;
      DP_NEXT, DP_RELAX: dir_q <= dir_e'(dir_q + 2'd1);
      DP_PD: begin
        idx_q <= pred_c;
        k_q   <= k_q - KW'(1);
      end
      DP_RESULT: begin
        out_q.found       <= found_q;
        out_q.distance    <= dist_q;
        out_q.path_length <= len_q;
        out_q.overflow    <= ovf_q;
        out_q.path_col    <= rd_hit_q ? CoordW'(path_rd[XW-1:0]) : '0;
        out_q.path_row    <= rd_hit_q ? CoordW'(path_rd[CW-1:XW]) : '0;
      end
      default: ;
    endcase
  end

  assign status_o.cmd        = req_q.cmd;
  assign status_o.run_ok     = run_ok;
  assign status_o.sweep_last = &sweep_q;
  assign status_o.open_empty = (total_q == '0);
  assign status_o.low_empty  = (cnt_q[sel_q] == '0);
  assign status_o.stale      = stale;
  assign status_o.at_goal    = (cur_q == goal_c);
  assign status_o.g_zero     = (cost_rd == '0);
  assign status_o.nb_ok      = nb_ok;
  assign status_o.last_dir   = (dir_q == DIR_YN);
  assign status_o.improve    = improve;
  assign status_o.full       = (total_q >= TW'(OPEN_DEPTH));
  assign status_o.k_one      = (k_q == KW'(1));
  assign out_rsp_o           = out_q;

`ifndef SYNTHESIS
  a_total_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q == cnt_q[0] + cnt_q[1]) else $error("open list count mismatch");
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TW'(OPEN_DEPTH)) else $error("open list beyond capacity");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == DP_POP) |-> (cnt_q[sel_q] != '0)) else $error("pop from empty level");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == DP_RELAX) |-> (total_q < TW'(OPEN_DEPTH))) else $error("push into full list");
`endif

endmodule

FILE: hdl/grid_astar_path_search.sv
// ----------------------------------------------------------------------------
// Grid A* path search
// Wall map loading, 4-neighbour A* search and path readback on a grid.
// ----------------------------------------------------------------------------
// Each request carries a command. A load writes one wall bit. A path read
// issues one registered read of the path memory. Either one is latched,
// decoded and then written to the response register once the previous
// response has been taken, and the block takes the next request after that.
// A run first sweeps the cost memory, one cell per cycle over MAX_WIDTH x
// MAX_HEIGHT cells, rounded up to powers of two per axis. Each entry taken
// from the open list is popped, read back and checked; each neighbour inside
// the grid is probed and then relaxed or skipped, and one outside it is
// skipped. Moving up to the next f level takes a swap step. Rebuilding the
// path writes a cell, then steps back; every step waits on a memory read.
// After reset the block clears its wall map in a pass of the same length as
// the cost sweep and accepts no request until it completes; configuration
// writes are taken at any time. One request is in work at a time, and a
// finished response waits in an output register while the next request is
// accepted. The open list is kept as two FIFO levels, for the current lowest
// f and that value plus two, which reproduces a list sorted by f with equal
// entries in arrival order.
// ----------------------------------------------------------------------------
module grid_astar_path_search #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64,
  parameter int unsigned OPEN_DEPTH = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  gaps_pkg::in_req_t         in_req_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output gaps_pkg::out_rsp_t        out_rsp_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  gaps_pkg::cfg_idx_e        cfg_index_i,
  input  logic [gaps_pkg::CfgW-1:0] cfg_data_i
);
  import gaps_pkg::*;

  dp_op_e     op;
  dp_status_t status;

  // Grid registers are plain flops and can take a write in any cycle.
  assign cfg_ready_o = 1'b1;

  gaps_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .out_valid_o,
    .out_ready_i,
    .status_i (status),
    .op_o     (op)
  );

  gaps_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .OPEN_DEPTH (OPEN_DEPTH)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .in_req_i,
    .cfg_valid_i,
    .cfg_index_i,
    .cfg_data_i,
    .op_i      (op),
    .status_o  (status),
    .out_rsp_o
  );

endmodule
